// ===== rtl/supersampled_primary_ray_generator_defines.svh =====
// assertion macros shared by the ray generator modules
// no dependencies; taken in by the files that carry checks
`ifndef SUPERSAMPLED_PRIMARY_RAY_GENERATOR_DEFINES_SVH
`define SUPERSAMPLED_PRIMARY_RAY_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SSPRG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssprg check failed");

// next-cycle implication, off during reset
`define SSPRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssprg check failed");

`endif

// ===== rtl/ssprg_pkg.sv =====
// shared types, widths and helper functions of the ray generator
// no dependencies; used by every module of the block
package ssprg_pkg;

  // block constants
  localparam int MAX_SUB_FACTOR = 8;
  localparam int PIXEL_BITS     = 12;
  localparam int COMPONENT_BITS = 21;
  localparam int NUM_AXES       = 3;

  // fixed field widths
  localparam int SF_W      = 4;
  localparam int VRES_W    = 13;
  localparam int JA_W      = 16;
  localparam int PACK_W    = 63;
  localparam int OUT_W     = 32;
  localparam int LFSR_W    = 32;
  localparam int R_W       = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h80200003;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_U = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_V = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EYE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUB    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VRES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER = 3'd6;

  localparam logic [SF_W-1:0]   SUB_RESET  = 4'd1;
  localparam logic [VRES_W-1:0] VRES_RESET = 13'd480;

  // subpixel counter and factor widths
  localparam int SUB_BITS = (MAX_SUB_FACTOR > 1) ? $clog2(MAX_SUB_FACTOR) : 1;
  localparam int M_W      = $clog2(MAX_SUB_FACTOR + 1);

  // datapath widths
  localparam int A_W    = PIXEL_BITS + SUB_BITS + 1;
  localparam int DIFF_W = ((VRES_W > PIXEL_BITS) ? VRES_W : PIXEL_BITS) + 1;
  localparam int B_W    = DIFF_W + SUB_BITS + 1;
  localparam int AS_W   = A_W + COMPONENT_BITS;
  localparam int BS_W   = B_W + COMPONENT_BITS;
  localparam int PU_W   = R_W + COMPONENT_BITS;
  localparam int PH_W   = PU_W - JA_W;
  localparam int HI_W   = PH_W + JA_W + 1;
  localparam int LO_W   = 2 * JA_W;
  localparam int HS_W   = HI_W + 1;
  localparam int JS_W   = HS_W - JA_W;
  localparam int ORG_W  = B_W + COMPONENT_BITS + 3;
  localparam int DIR_W  = ORG_W + 1;

  localparam int PIPE_STAGES = 5;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] origin_x;
    logic signed [OUT_W-1:0] origin_y;
    logic signed [OUT_W-1:0] origin_z;
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    logic                    last_ray;
  } ray_t;

  typedef struct packed {
    logic [PACK_W-1:0] step_u;
    logic [PACK_W-1:0] step_v;
    logic [PACK_W-1:0] corner;
    logic [PACK_W-1:0] eye;
    logic [SF_W-1:0]   sub_factor;
    logic [VRES_W-1:0] vres;
    logic [JA_W-1:0]   jitter_amount;
  } cfg_t;

  typedef struct packed {
    logic                load;
    logic                issue;
    logic                last;
    logic [SUB_BITS-1:0] sub_col;
    logic [SUB_BITS-1:0] sub_row;
  } ctrl_cmd_t;

  // effective subpixel factor: zero acts as one, large values clamp
  function automatic logic [M_W-1:0] eff_m(input logic [SF_W-1:0] sf);
    logic [M_W-1:0] m;
    if (sf == '0) begin
      m = M_W'(1);
    end else if (sf > SF_W'(MAX_SUB_FACTOR)) begin
      m = M_W'(MAX_SUB_FACTOR);
    end else begin
      m = M_W'(sf);
    end
    return m;
  endfunction

  // one signed component out of a packed vector, x lowest
  function automatic logic signed [COMPONENT_BITS-1:0] comp(
    input logic [PACK_W-1:0] p,
    input int                idx
  );
    return $signed(p[idx*COMPONENT_BITS +: COMPONENT_BITS]);
  endfunction

  // galois lfsr, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIR_W-1:0] v);
    logic [DIR_W-OUT_W:0]    top;
    logic signed [OUT_W-1:0] r;
    top = v[DIR_W-1:OUT_W-1];
    if (top == '0 || top == '1) begin
      r = v[OUT_W-1:0];
    end else if (v[DIR_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/ssprg_cfg.sv =====
// configuration register file of the ray generator
// depends on ssprg_pkg
module ssprg_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ssprg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssprg_pkg::PACK_W-1:0]    cfg_data,
  output ssprg_pkg::cfg_t                 cfg
);

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_u        <= '0;
      cfg.step_v        <= '0;
      cfg.corner        <= '0;
      cfg.eye           <= '0;
      cfg.sub_factor    <= ssprg_pkg::SUB_RESET;
      cfg.vres          <= ssprg_pkg::VRES_RESET;
      cfg.jitter_amount <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ssprg_pkg::REG_STEP_U: cfg.step_u <= cfg_data;
        ssprg_pkg::REG_STEP_V: cfg.step_v <= cfg_data;
        ssprg_pkg::REG_CORNER: cfg.corner <= cfg_data;
        ssprg_pkg::REG_EYE:    cfg.eye    <= cfg_data;
        ssprg_pkg::REG_SUB:    cfg.sub_factor <= cfg_data[ssprg_pkg::SF_W-1:0];
        ssprg_pkg::REG_VRES:   cfg.vres <= cfg_data[ssprg_pkg::VRES_W-1:0];
        ssprg_pkg::REG_JITTER: cfg.jitter_amount <= cfg_data[ssprg_pkg::JA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ssprg_ctrl.sv =====
// controller: takes a pixel word and walks the subpixel grid, one ray per issue
// depends on ssprg_pkg and the assertion macro header
`include "supersampled_primary_ray_generator_defines.svh"

module ssprg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  ssprg_pkg::cfg_t      cfg,
  input  logic                 advance,
  output ssprg_pkg::ctrl_cmd_t cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t                           state;
  logic [ssprg_pkg::SUB_BITS-1:0]   sub_col;
  logic [ssprg_pkg::SUB_BITS-1:0]   sub_row;
  logic [ssprg_pkg::M_W-1:0]        m;
  logic                             col_end;
  logic                             row_end;

  // grid limits
  assign m       = ssprg_pkg::eff_m(cfg.sub_factor);
  assign col_end = ssprg_pkg::M_W'(sub_col) == m - ssprg_pkg::M_W'(1);
  assign row_end = ssprg_pkg::M_W'(sub_row) == m - ssprg_pkg::M_W'(1);

  // commands to the datapath
  assign pixel_stall = (state != IDLE);
  assign cmd.load    = (state == IDLE) && pixel_valid;
  assign cmd.issue   = (state == RUN) && advance;
  assign cmd.last    = col_end && row_end;
  assign cmd.sub_col = sub_col;
  assign cmd.sub_row = sub_row;

  // state and subpixel counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      sub_col <= '0;
      sub_row <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (cmd.issue) begin
            if (cmd.last) begin
              state   <= IDLE;
              sub_col <= '0;
              sub_row <= '0;
            end else if (col_end) begin
              sub_col <= '0;
              sub_row <= sub_row + 1'b1;
            end else begin
              sub_col <= sub_col + 1'b1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // checks
  `SSPRG_ASSERT_NEXT(a_last_to_idle, clk, rst, cmd.issue && cmd.last, state == IDLE)
  `SSPRG_ASSERT_IMPL(a_idle_grid_zero, clk, rst, state == IDLE, sub_col == '0 && sub_row == '0)
  `SSPRG_ASSERT_IMPL(a_grid_in_range, clk, rst, state == RUN, ssprg_pkg::M_W'(sub_col) < m && ssprg_pkg::M_W'(sub_row) < m)

endmodule

// ===== rtl/ssprg_dp.sv =====
// datapath: pixel bases, jitter lfsr, ray pipeline and output register
// depends on ssprg_pkg and the assertion macro header
`include "supersampled_primary_ray_generator_defines.svh"

module ssprg_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ssprg_pkg::cfg_t      cfg,
  input  ssprg_pkg::pixel_t    pixel,
  input  ssprg_pkg::ctrl_cmd_t cmd,
  output logic                 advance,
  output logic                 ray_valid,
  input  logic                 ray_stall,
  output ssprg_pkg::ray_t      ray
);

  logic [ssprg_pkg::M_W-1:0]              m;
  logic                                   jit;
  logic signed [ssprg_pkg::DIFF_W-1:0]    row_diff;
  logic [ssprg_pkg::A_W-1:0]              col_base;
  logic signed [ssprg_pkg::B_W-1:0]       row_base;
  logic [ssprg_pkg::LFSR_W-1:0]           lfsr;
  logic [ssprg_pkg::LFSR_W-1:0]           draw_u;
  logic [ssprg_pkg::LFSR_W-1:0]           draw_v;
  logic signed [ssprg_pkg::R_W-1:0]       rnd_u;
  logic signed [ssprg_pkg::R_W-1:0]       rnd_v;
  logic [ssprg_pkg::PIPE_STAGES-1:0]      vld;
  logic [ssprg_pkg::PIPE_STAGES-1:0]      lst;

  // stage 1: subpixel indexes and draws
  logic signed [ssprg_pkg::A_W-1:0]       s1_a;
  logic signed [ssprg_pkg::B_W-1:0]       s1_b;
  logic signed [ssprg_pkg::R_W-1:0]       s1_ru;
  logic signed [ssprg_pkg::R_W-1:0]       s1_rv;
  // stage 2: step products
  logic signed [ssprg_pkg::AS_W-1:0]      s2_as [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::BS_W-1:0]      s2_bs [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::PU_W-1:0]      s2_pu [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::PU_W-1:0]      s2_pv [ssprg_pkg::NUM_AXES];
  // stage 3: base sum and jitter partial products
  logic signed [ssprg_pkg::ORG_W-1:0]     s3_base [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::HI_W-1:0]      s3_hu [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::HI_W-1:0]      s3_hv [ssprg_pkg::NUM_AXES];
  logic [ssprg_pkg::LO_W-1:0]             s3_lu [ssprg_pkg::NUM_AXES];
  logic [ssprg_pkg::LO_W-1:0]             s3_lv [ssprg_pkg::NUM_AXES];
  // stage 4: floored jitter offsets
  logic signed [ssprg_pkg::HS_W-1:0]      hs_u [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::HS_W-1:0]      hs_v [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::ORG_W-1:0]     s4_base [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::JS_W-1:0]      s4_ju [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::JS_W-1:0]      s4_jv [ssprg_pkg::NUM_AXES];
  // stage 5: exact origin
  logic signed [ssprg_pkg::ORG_W-1:0]     s5_org [ssprg_pkg::NUM_AXES];
  // output: saturation
  logic signed [ssprg_pkg::DIR_W-1:0]     org_ext [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::DIR_W-1:0]     dir_full [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::OUT_W-1:0]     org_sat [ssprg_pkg::NUM_AXES];
  logic signed [ssprg_pkg::OUT_W-1:0]     dir_sat [ssprg_pkg::NUM_AXES];

  // whole pipeline moves unless the output word is held
  assign advance = !ray_valid || !ray_stall;

  // factor, row flip and two lfsr draws for the next ray
  assign m        = ssprg_pkg::eff_m(cfg.sub_factor);
  assign jit      = (m != ssprg_pkg::M_W'(1));
  assign row_diff = $signed(ssprg_pkg::DIFF_W'(cfg.vres))
                  - $signed(ssprg_pkg::DIFF_W'(pixel.pixel_y));
  assign draw_u   = ssprg_pkg::lfsr_step(lfsr);
  assign draw_v   = ssprg_pkg::lfsr_step(draw_u);
  assign rnd_u    = jit ? $signed({~draw_u[ssprg_pkg::R_W-1], draw_u[ssprg_pkg::R_W-2:0]}) : '0;
  assign rnd_v    = jit ? $signed({~draw_v[ssprg_pkg::R_W-1], draw_v[ssprg_pkg::R_W-2:0]}) : '0;

  // jitter high part plus carried low part, floored by the shift
  always_comb begin
    for (int i = 0; i < ssprg_pkg::NUM_AXES; i++) begin
      hs_u[i] = ssprg_pkg::HS_W'(s3_hu[i])
              + $signed(ssprg_pkg::HS_W'(s3_lu[i][ssprg_pkg::LO_W-1:ssprg_pkg::JA_W]));
      hs_v[i] = ssprg_pkg::HS_W'(s3_hv[i])
              + $signed(ssprg_pkg::HS_W'(s3_lv[i][ssprg_pkg::LO_W-1:ssprg_pkg::JA_W]));
    end
  end

  // direction and clamping
  always_comb begin
    for (int i = 0; i < ssprg_pkg::NUM_AXES; i++) begin
      org_ext[i]  = ssprg_pkg::DIR_W'(s5_org[i]);
      dir_full[i] = org_ext[i] - ssprg_pkg::DIR_W'(ssprg_pkg::comp(cfg.eye, i));
      org_sat[i]  = ssprg_pkg::sat_out(org_ext[i]);
      dir_sat[i]  = ssprg_pkg::sat_out(dir_full[i]);
    end
  end

  // control state: lfsr and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr      <= ssprg_pkg::LFSR_SEED;
      vld       <= '0;
      ray_valid <= 1'b0;
    end else begin
      if (cmd.issue && jit) begin
        lfsr <= draw_v;
      end
      if (advance) begin
        vld       <= {vld[ssprg_pkg::PIPE_STAGES-2:0], cmd.issue};
        ray_valid <= vld[ssprg_pkg::PIPE_STAGES-1];
      end
    end
  end

  // pixel bases, latched with the pixel word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_base <= ssprg_pkg::A_W'(pixel.pixel_x) * ssprg_pkg::A_W'(m);
      row_base <= ssprg_pkg::B_W'(row_diff) * $signed(ssprg_pkg::B_W'(m));
    end
  end

  // ray pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      lst  <= {lst[ssprg_pkg::PIPE_STAGES-2:0], cmd.last};
      s1_a  <= $signed(col_base + ssprg_pkg::A_W'(cmd.sub_col));
      s1_b  <= row_base + $signed(ssprg_pkg::B_W'(cmd.sub_row));
      s1_ru <= rnd_u;
      s1_rv <= rnd_v;
      for (int i = 0; i < ssprg_pkg::NUM_AXES; i++) begin
        s2_as[i] <= ssprg_pkg::AS_W'(s1_a)
                  * ssprg_pkg::AS_W'(ssprg_pkg::comp(cfg.step_u, i));
        s2_bs[i] <= ssprg_pkg::BS_W'(s1_b)
                  * ssprg_pkg::BS_W'(ssprg_pkg::comp(cfg.step_v, i));
        s2_pu[i] <= ssprg_pkg::PU_W'(s1_ru)
                  * ssprg_pkg::PU_W'(ssprg_pkg::comp(cfg.step_u, i));
        s2_pv[i] <= ssprg_pkg::PU_W'(s1_rv)
                  * ssprg_pkg::PU_W'(ssprg_pkg::comp(cfg.step_v, i));

        s3_base[i] <= ssprg_pkg::ORG_W'(ssprg_pkg::comp(cfg.corner, i))
                    + ssprg_pkg::ORG_W'(s2_as[i]) + ssprg_pkg::ORG_W'(s2_bs[i]);
        s3_hu[i] <= ssprg_pkg::HI_W'($signed(s2_pu[i][ssprg_pkg::PU_W-1:ssprg_pkg::JA_W]))
                  * $signed(ssprg_pkg::HI_W'(cfg.jitter_amount));
        s3_hv[i] <= ssprg_pkg::HI_W'($signed(s2_pv[i][ssprg_pkg::PU_W-1:ssprg_pkg::JA_W]))
                  * $signed(ssprg_pkg::HI_W'(cfg.jitter_amount));
        s3_lu[i] <= ssprg_pkg::LO_W'(s2_pu[i][ssprg_pkg::JA_W-1:0])
                  * ssprg_pkg::LO_W'(cfg.jitter_amount);
        s3_lv[i] <= ssprg_pkg::LO_W'(s2_pv[i][ssprg_pkg::JA_W-1:0])
                  * ssprg_pkg::LO_W'(cfg.jitter_amount);

        s4_base[i] <= s3_base[i];
        s4_ju[i]   <= hs_u[i][ssprg_pkg::HS_W-1:ssprg_pkg::JA_W];
        s4_jv[i]   <= hs_v[i][ssprg_pkg::HS_W-1:ssprg_pkg::JA_W];

        s5_org[i] <= s4_base[i] + ssprg_pkg::ORG_W'(s4_ju[i]) + ssprg_pkg::ORG_W'(s4_jv[i]);
      end
      ray.origin_x <= org_sat[0];
      ray.origin_y <= org_sat[1];
      ray.origin_z <= org_sat[2];
      ray.dir_x    <= dir_sat[0];
      ray.dir_y    <= dir_sat[1];
      ray.dir_z    <= dir_sat[2];
      ray.last_ray <= lst[ssprg_pkg::PIPE_STAGES-1];
    end
  end

  // checks
  `SSPRG_ASSERT_NEXT(a_frozen_pipe, clk, rst, !advance, $stable(vld) && $stable(lfsr))

endmodule

// ===== rtl/supersampled_primary_ray_generator.sv =====
// top level of the supersampled pinhole ray generator
// depends on ssprg_pkg, ssprg_cfg, ssprg_ctrl and ssprg_dp
//
//   channel  | handshake                | word
//   ---------+--------------------------+-----------------------------------
//   pixel    | pixel_valid, pixel_stall | ssprg_pkg::pixel_t (x, y)
//   ray      | ray_valid, ray_stall     | ssprg_pkg::ray_t (origin, dir, last)
//   config   | cfg_write, cfg_index     | cfg_data, one register per write
//
// a pixel word with factor m gives m*m rays: the word is taken in IDLE, then
// one ray is issued per cycle by the subpixel counter in the controller while the output is not stalled;
// the next pixel is taken the cycle after the last ray of the current one is issued.
// each ray leaves after issue through a five-stage pipeline and the
// output register; a stalled output word freezes the whole pipeline.
// reset is synchronous, with no clearing pass.
module supersampled_primary_ray_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  ssprg_pkg::pixel_t               pixel,
  output logic                            ray_valid,
  input  logic                            ray_stall,
  output ssprg_pkg::ray_t                 ray,
  input  logic                            cfg_write,
  input  logic [ssprg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssprg_pkg::PACK_W-1:0]    cfg_data
);

  ssprg_pkg::cfg_t      cfg;
  ssprg_pkg::ctrl_cmd_t cmd;
  logic                 advance;

  // configuration registers
  ssprg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // subpixel sequencer
  ssprg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .cfg         (cfg),
    .advance     (advance),
    .cmd         (cmd)
  );

  // ray arithmetic
  ssprg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixel     (pixel),
    .cmd       (cmd),
    .advance   (advance),
    .ray_valid (ray_valid),
    .ray_stall (ray_stall),
    .ray       (ray)
  );

endmodule

// ===== tb/tb_supersampled_primary_ray_generator.sv =====
// self-checking testbench for the supersampled primary ray generator
// depends on ssprg_pkg and the supersampled_primary_ray_generator rtl
// pixel words go in from a queue, ray words are checked against a local camera model
`timescale 1ns / 100ps

module tb_supersampled_primary_ray_generator;

  localparam int     STUCK_LIMIT = 5000;
  localparam int     PRINT_LIMIT = 40;
  localparam longint OUT_MAX     = 64'sd2147483647;
  localparam longint OUT_MIN     = -64'sd2147483648;
  // index with no register behind it
  localparam logic [ssprg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            pixel_valid = 1'b0;
  logic                            pixel_stall;
  ssprg_pkg::pixel_t               pixel       = '0;
  logic                            ray_valid;
  logic                            ray_stall   = 1'b0;
  ssprg_pkg::ray_t                 ray;
  logic                            cfg_write   = 1'b0;
  logic [ssprg_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [ssprg_pkg::PACK_W-1:0]    cfg_data    = '0;

  // camera settings as the block should hold them
  logic [ssprg_pkg::PACK_W-1:0] step_u_reg = '0;
  logic [ssprg_pkg::PACK_W-1:0] step_v_reg = '0;
  logic [ssprg_pkg::PACK_W-1:0] corner_reg = '0;
  logic [ssprg_pkg::PACK_W-1:0] eye_reg    = '0;
  logic [ssprg_pkg::SF_W-1:0]   sub_reg    = ssprg_pkg::SUB_RESET;
  logic [ssprg_pkg::VRES_W-1:0] vres_reg   = ssprg_pkg::VRES_RESET;
  logic [ssprg_pkg::JA_W-1:0]   jitter_reg = '0;
  logic [ssprg_pkg::LFSR_W-1:0] jitter_state = ssprg_pkg::LFSR_SEED;

  ssprg_pkg::pixel_t pending_pixels[$];
  ssprg_pkg::ray_t   expected_rays[$];

  int send_idle_pct  = 0;
  int ray_stall_pct  = 0;
  int errors         = 0;
  int pixels_sent    = 0;
  int rays_checked   = 0;
  int settings_count = 0;
  int stuck_cycles   = 0;

  supersampled_primary_ray_generator dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .ray_valid   (ray_valid),
    .ray_stall   (ray_stall),
    .ray         (ray),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // signed component k of a packed vector, x lowest
  function automatic longint vec_comp(input logic [ssprg_pkg::PACK_W-1:0] v, input int k);
    logic signed [ssprg_pkg::COMPONENT_BITS-1:0] c;
    c = v[k*ssprg_pkg::COMPONENT_BITS +: ssprg_pkg::COMPONENT_BITS];
    return longint'(c);
  endfunction

  function automatic logic signed [ssprg_pkg::OUT_W-1:0] clamp32(input longint v);
    if (v > OUT_MAX) return {1'b0, {(ssprg_pkg::OUT_W-1){1'b1}}};
    if (v < OUT_MIN) return {1'b1, {(ssprg_pkg::OUT_W-1){1'b0}}};
    return v[ssprg_pkg::OUT_W-1:0];
  endfunction

  // advance the jitter lfsr once and return the signed Q1.16 offset
  function automatic longint jitter_draw();
    logic out_bit;
    out_bit = jitter_state[0];
    jitter_state = jitter_state >> 1;
    if (out_bit) jitter_state = jitter_state ^ ssprg_pkg::LFSR_MASK;
    return longint'(jitter_state[ssprg_pkg::R_W-1:0]) - 65536;
  endfunction

  // all rays of one pixel word, in row-major subpixel order
  task automatic predict_pixel_rays(input ssprg_pkg::pixel_t p);
    longint su[3], sv[3], co[3], ey[3];
    longint m, col_base, row_base, a, b, ku, kv, org, sr, sc;
    logic signed [ssprg_pkg::OUT_W-1:0] org_out[3], dir_out[3];
    ssprg_pkg::ray_t r;
    int k;
    m = longint'(sub_reg);
    if (m < 1) m = 1;
    if (m > ssprg_pkg::MAX_SUB_FACTOR) m = ssprg_pkg::MAX_SUB_FACTOR;
    for (k = 0; k < 3; k++) begin
      su[k] = vec_comp(step_u_reg, k);
      sv[k] = vec_comp(step_v_reg, k);
      co[k] = vec_comp(corner_reg, k);
      ey[k] = vec_comp(eye_reg, k);
    end
    col_base = longint'(p.pixel_x) * m;
    // row flip may go negative and is kept that way
    row_base = (longint'(vres_reg) - longint'(p.pixel_y)) * m;
    for (sr = 0; sr < m; sr++) begin
      for (sc = 0; sc < m; sc++) begin
        a  = col_base + sc;
        b  = row_base + sr;
        ku = 0;
        kv = 0;
        if (m > 1) begin
          ku = jitter_draw() * longint'(jitter_reg);
          kv = jitter_draw() * longint'(jitter_reg);
        end
        for (k = 0; k < 3; k++) begin
          org = co[k] + a * su[k] + b * sv[k];
          if (m > 1) org = org + ((ku * su[k]) >>> 32) + ((kv * sv[k]) >>> 32);
          org_out[k] = clamp32(org);
          dir_out[k] = clamp32(org - ey[k]);
        end
        r.origin_x = org_out[0];
        r.origin_y = org_out[1];
        r.origin_z = org_out[2];
        r.dir_x    = dir_out[0];
        r.dir_y    = dir_out[1];
        r.dir_z    = dir_out[2];
        r.last_ray = (sr == m - 1) && (sc == m - 1);
        expected_rays = {expected_rays, r};
      end
    end
  endtask

  task automatic check_field(input string name,
                             input logic signed [ssprg_pkg::OUT_W-1:0] want,
                             input logic signed [ssprg_pkg::OUT_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // pixel driver: holds a word until it is taken
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        predict_pixel_rays(pixel);
        pixels_sent++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel       <= pending_pixels.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // ray monitor: compares each taken word with the oldest expected ray
  always @(posedge clk) begin
    ssprg_pkg::ray_t want;
    if (rst) begin
      ray_stall <= 1'b0;
    end else begin
      if (ray_valid && !ray_stall) begin
        rays_checked++;
        if (expected_rays.size() == 0) begin
          errors++;
          if (errors <= PRINT_LIMIT)
            $display("%0t: unexpected ray word, expected none, actual %h", $time, ray);
        end else begin
          want = expected_rays.pop_front();
          check_field("origin_x", want.origin_x, ray.origin_x);
          check_field("origin_y", want.origin_y, ray.origin_y);
          check_field("origin_z", want.origin_z, ray.origin_z);
          check_field("dir_x", want.dir_x, ray.dir_x);
          check_field("dir_y", want.dir_y, ray.dir_y);
          check_field("dir_z", want.dir_z, ray.dir_z);
          check_field("last_ray", ssprg_pkg::OUT_W'(want.last_ray),
                      ssprg_pkg::OUT_W'(ray.last_ray));
        end
      end
      ray_stall <= ($urandom_range(99) < ray_stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (ray_valid && !ray_stall) || cfg_write)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one register write; the local copy follows
  task automatic write_reg(input logic [ssprg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ssprg_pkg::PACK_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      ssprg_pkg::REG_STEP_U: step_u_reg = data;
      ssprg_pkg::REG_STEP_V: step_v_reg = data;
      ssprg_pkg::REG_CORNER: corner_reg = data;
      ssprg_pkg::REG_EYE:    eye_reg    = data;
      ssprg_pkg::REG_SUB:    sub_reg    = data[ssprg_pkg::SF_W-1:0];
      ssprg_pkg::REG_VRES:   vres_reg   = data[ssprg_pkg::VRES_W-1:0];
      ssprg_pkg::REG_JITTER: jitter_reg = data[ssprg_pkg::JA_W-1:0];
      default: ;
    endcase
  endtask

  // random upper bits over a narrow register value
  function automatic logic [ssprg_pkg::PACK_W-1:0] junk_above(
    input logic [ssprg_pkg::PACK_W-1:0] v,
    input int                           w
  );
    logic [ssprg_pkg::PACK_W-1:0] d;
    d = ssprg_pkg::PACK_W'({$urandom, $urandom});
    for (int i = 0; i < w; i++) d[i] = v[i];
    return d;
  endfunction

  function automatic logic [ssprg_pkg::PACK_W-1:0] pack_vec(input int x, input int y,
                                                             input int z);
    return {ssprg_pkg::COMPONENT_BITS'(z), ssprg_pkg::COMPONENT_BITS'(y),
            ssprg_pkg::COMPONENT_BITS'(x)};
  endfunction

  // either a full-range component or a small one that keeps sums in range
  function automatic int rand_comp();
    if ($urandom_range(1)) return int'($urandom_range(0, 2097151));
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic logic [ssprg_pkg::PACK_W-1:0] rand_vec();
    return pack_vec(rand_comp(), rand_comp(), rand_comp());
  endfunction

  function automatic logic [ssprg_pkg::PIXEL_BITS-1:0] rand_coord();
    if ($urandom_range(1)) return ssprg_pkg::PIXEL_BITS'($urandom);
    return ssprg_pkg::PIXEL_BITS'($urandom_range(0, 63));
  endfunction

  task automatic load_settings(input logic [ssprg_pkg::PACK_W-1:0] su,
                               input logic [ssprg_pkg::PACK_W-1:0] sv,
                               input logic [ssprg_pkg::PACK_W-1:0] co,
                               input logic [ssprg_pkg::PACK_W-1:0] ey,
                               input logic [ssprg_pkg::SF_W-1:0]   sf,
                               input logic [ssprg_pkg::VRES_W-1:0] vr,
                               input logic [ssprg_pkg::JA_W-1:0]   ja);
    write_reg(ssprg_pkg::REG_STEP_U, su);
    write_reg(ssprg_pkg::REG_STEP_V, sv);
    write_reg(ssprg_pkg::REG_CORNER, co);
    write_reg(ssprg_pkg::REG_EYE, ey);
    write_reg(ssprg_pkg::REG_SUB,
              junk_above(ssprg_pkg::PACK_W'(sf), ssprg_pkg::SF_W));
    write_reg(ssprg_pkg::REG_VRES,
              junk_above(ssprg_pkg::PACK_W'(vr), ssprg_pkg::VRES_W));
    write_reg(ssprg_pkg::REG_JITTER,
              junk_above(ssprg_pkg::PACK_W'(ja), ssprg_pkg::JA_W));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  task automatic queue_pixel(input logic [ssprg_pkg::PIXEL_BITS-1:0] x,
                             input logic [ssprg_pkg::PIXEL_BITS-1:0] y);
    ssprg_pkg::pixel_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    pending_pixels = {pending_pixels, p};
  endtask

  // block is idle once every queued pixel went in and every ray came out
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pixel_valid || expected_rays.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [ssprg_pkg::SF_W-1:0]   sf;
    logic [ssprg_pkg::VRES_W-1:0] vr;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // settings straight out of reset
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    wait_drained();

    // modest camera, factor two, full jitter
    load_settings(pack_vec(512, 37, -300), pack_vec(-20, 480, 64),
                  pack_vec(-160000, -90000, 4096), pack_vec(1000, -2000, -40960),
                  4'd2, 13'd480, 16'hFFFF);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(100, 200);
    wait_drained();

    // factor zero acts as one, zero height makes the row flip negative
    load_settings(pack_vec(300, -7, 11), pack_vec(5, 200, -9),
                  pack_vec(1, 2, 3), pack_vec(-4, -5, -6), 4'd0, 13'd0, 16'h1234);
    queue_pixel(5, 7);
    queue_pixel(4095, 4095);
    wait_drained();

    // factor above the limit, largest components and height: positive saturation
    load_settings(pack_vec(1048575, 1048575, 1048575),
                  pack_vec(1048575, 1048575, 1048575),
                  pack_vec(1048575, 1048575, 1048575),
                  pack_vec(-1048576, -1048576, -1048576), 4'd15, 13'd8191, 16'hFFFF);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    wait_drained();

    // most negative components: negative saturation, no jitter
    load_settings(pack_vec(-1048576, -1048576, -1048576),
                  pack_vec(-1048576, -1048576, -1048576),
                  pack_vec(-1048576, -1048576, -1048576),
                  pack_vec(1048575, 1048575, 1048575), 4'd9, 13'd1, 16'h0000);
    queue_pixel(4095, 0);
    queue_pixel(4095, 4095);
    wait_drained();

    // unused register index is ignored; factor one leaves the lfsr alone
    write_reg(REG_UNUSED, ssprg_pkg::PACK_W'({$urandom, $urandom}));
    load_settings(pack_vec(4096, 0, 0), pack_vec(0, 4096, 0), pack_vec(-8, -8, -8),
                  pack_vec(0, 0, -4096), 4'd1, 13'd4096, 16'hABCD);
    queue_pixel(1, 1);
    wait_drained();

    // random settings under each idling mode
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  ray_stall_pct = 0;  end
        1: begin send_idle_pct = 72; ray_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ray_stall_pct = 72; end
        default: begin send_idle_pct = 37; ray_stall_pct = 37; end
      endcase
      for (int s = 0; s < 2; s++) begin
        sf = ($urandom_range(99) < 70) ? ssprg_pkg::SF_W'($urandom_range(0, 4))
                                       : ssprg_pkg::SF_W'($urandom);
        vr = $urandom_range(1) ? ssprg_pkg::VRES_W'($urandom)
                               : ssprg_pkg::VRES_W'($urandom_range(1, 600));
        load_settings(rand_vec(), rand_vec(), rand_vec(), rand_vec(), sf, vr,
                      ssprg_pkg::JA_W'($urandom));
        for (int n = 0; n < 16; n++) queue_pixel(rand_coord(), rand_coord());
        wait_drained();
      end
    end

    // let the pipeline settle and catch any stray ray
    repeat (12) @(posedge clk);
    if (expected_rays.size() != 0) begin
      errors += expected_rays.size();
      $display("%0t: %0d expected rays never arrived", $time, expected_rays.size());
    end
    $display("covered %0d pixel words and %0d ray words over %0d camera settings",
             pixels_sent, rays_checked, settings_count);
    $display("idling modes: none, sender 72%%, receiver 72%%, both 37%%; %0d errors", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
